@@ rtl/tcw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the text console writer.
package tcw_pkg;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [7:0]  ATTR_RESET   = 8'h0F;
    localparam logic [15:0] RESET_WORD   = {ATTR_RESET, SPACE_CODE};

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUT     = 3'd0,
        OP_NEWLINE = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_READ    = 3'd3,
        OP_NOP     = 3'd4
    } tcw_op_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_SCROLL = 4'b0100,
        ST_FILL   = 4'b1000
    } tcw_state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } tcw_cmd_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic        did_scroll;
        logic [15:0] read_data;
    } tcw_rsp_t;

    typedef struct packed {
        tcw_op_t     op;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } tcw_entry_t;

    typedef struct packed {
        logic       push;
        tcw_entry_t entry;
    } tcw_push_t;

endpackage

@@ rtl/tcw_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts command beats and classifies them into queue entries.
module tcw_front
    import tcw_pkg::*;
#(
    parameter int CELL_COUNT = 2000
) (
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  tcw_cmd_t  cmd_data,
    input  logic      q_full,
    input  logic      init_busy,
    output tcw_push_t q_push
);

    logic    in_range;
    tcw_op_t op;

    assign in_range  = (32'(cmd_data.cell_index) < 32'(CELL_COUNT));
    assign cmd_stall = q_full | init_busy;

    always_comb
    begin
        case (cmd_data.mode)
            MODE_PUT:
            begin
                op = (cmd_data.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
            end
            MODE_CLEAR:
            begin
                op = OP_CLEAR;
            end
            MODE_READ:
            begin
                // An out-of-range read reports zero, which is what a no-op gives.
                op = in_range ? OP_READ : OP_NOP;
            end
            default:
            begin
                op = OP_NOP;
            end
        endcase
    end

    assign q_push.push             = cmd_valid & ~cmd_stall;
    assign q_push.entry.op         = op;
    assign q_push.entry.char_code  = cmd_data.char_code;
    assign q_push.entry.cell_index = cmd_data.cell_index;

endmodule

@@ rtl/tcw_queue.sv @@
`timescale 1ns / 1ps
// Short command queue between the front end and the execution engine.
module tcw_queue
    import tcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tcw_push_t  q_push,
    output logic       q_full,
    input  logic       pop,
    output logic       q_valid,
    output tcw_entry_t head
);

    tcw_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   wptr_next;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QPTR_W-1:0]   rptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_pop;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = slot_reg[rptr_reg];
    assign do_pop  = pop & q_valid;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (q_push.push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (q_push.push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !q_push.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.push)
        begin
            slot_reg[wptr_reg] <= q_push.entry;
        end
    end

endmodule

@@ rtl/tcw_back.sv @@
`timescale 1ns / 1ps
// Execution engine: screen memory, cursor, scroll and clear sweeps, result register.
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  tcw_entry_t head,
    output logic       pop,
    output logic       init_busy,
    input  logic       cfg_valid,
    input  logic [7:0] cfg_data,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output tcw_rsp_t   rsp_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int MW         = $clog2(CELL_COUNT);
    localparam int AW         = $clog2(CELL_COUNT + 1);
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);

    logic [15:0]   mem [CELL_COUNT];
    logic [15:0]   rd_data_reg;

    tcw_state_t    state_reg;
    tcw_state_t    state_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [MW-1:0] addr_reg;
    logic [MW-1:0] addr_next;
    logic [MW-1:0] base_reg;
    logic [MW-1:0] base_next;
    logic [AW-1:0] src_reg;
    logic [AW-1:0] src_next;
    logic [AW-1:0] dst_reg;
    logic [AW-1:0] dst_next;
    logic          wpend_reg;
    logic          wpend_next;
    logic          init_reg;
    logic          init_next;
    logic          scroll_reg;
    logic          scroll_next;
    logic [15:0]   fill_word_reg;
    logic [15:0]   fill_word_next;
    logic [7:0]    attr_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    tcw_rsp_t      out_reg;
    tcw_rsp_t      out_next;

    logic          wr_en;
    logic [MW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [MW-1:0] rd_addr;
    logic          load_out;
    logic          res_scroll;
    logic [15:0]   res_data;
    logic          line_end;

    logic [CW+6:0] col_ext;
    logic [RW+4:0] row_ext;
    logic [MW+10:0] cell_ext;

    assign cell_ext  = {{MW{1'b0}}, head.cell_index};
    assign col_ext   = {7'd0, col_next};
    assign row_ext   = {5'd0, row_next};
    assign init_busy = init_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        addr_next      = addr_reg;
        base_next      = base_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        wpend_next     = 1'b0;
        init_next      = init_reg;
        scroll_next    = scroll_reg;
        fill_word_next = fill_word_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = {attr_reg, head.char_code};
        rd_en          = 1'b0;
        rd_addr        = cell_ext[MW-1:0];
        pop            = 1'b0;
        load_out       = 1'b0;
        res_scroll     = 1'b0;
        res_data       = 16'd0;
        line_end       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    pop = 1'b1;
                    case (head.op)
                        OP_PUT:
                        begin
                            wr_en = 1'b1;
                            if (col_reg == CW'(COLUMNS - 1))
                            begin
                                line_end = 1'b1;
                            end
                            else
                            begin
                                col_next  = col_reg + 1'b1;
                                addr_next = addr_reg + 1'b1;
                                load_out  = 1'b1;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            line_end = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            col_next       = '0;
                            row_next       = '0;
                            addr_next      = '0;
                            base_next      = '0;
                            dst_next       = '0;
                            scroll_next    = 1'b0;
                            fill_word_next = {attr_reg, SPACE_CODE};
                            state_next     = ST_FILL;
                        end
                        OP_READ:
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase

                    if (line_end)
                    begin
                        col_next = '0;
                        if (row_reg == RW'(ROWS - 1))
                        begin
                            // The cursor stays at the start of the bottom row.
                            addr_next      = base_reg;
                            src_next       = AW'(COLUMNS);
                            dst_next       = '0;
                            scroll_next    = 1'b1;
                            fill_word_next = {attr_reg, SPACE_CODE};
                            state_next     = ST_SCROLL;
                        end
                        else
                        begin
                            row_next  = row_reg + 1'b1;
                            base_next = base_reg + MW'(COLUMNS);
                            addr_next = base_reg + MW'(COLUMNS);
                            load_out  = 1'b1;
                        end
                    end
                end
            end
            ST_READ:
            begin
                res_data   = rd_data_reg;
                load_out   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCROLL:
            begin
                // Each read is written back in the next cycle to the cell one row higher.
                rd_addr = src_reg[MW-1:0];
                wr_addr = dst_reg[MW-1:0];
                wr_data = rd_data_reg;
                if (src_reg != AW'(CELL_COUNT))
                begin
                    rd_en      = 1'b1;
                    src_next   = src_reg + 1'b1;
                    wpend_next = 1'b1;
                end
                if (wpend_reg)
                begin
                    wr_en    = 1'b1;
                    dst_next = dst_reg + 1'b1;
                end
                else if (src_reg == AW'(CELL_COUNT))
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                wr_en    = 1'b1;
                wr_addr  = dst_reg[MW-1:0];
                wr_data  = fill_word_reg;
                dst_next = dst_reg + 1'b1;
                if (dst_reg == AW'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                    init_next  = 1'b0;
                    if (!init_reg)
                    begin
                        res_scroll = scroll_reg;
                        load_out   = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next            = out_reg;
        out_valid_next      = out_valid_reg;
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next      = 1'b1;
            out_next.cursor_col = col_ext[6:0];
            out_next.cursor_row = row_ext[4:0];
            out_next.did_scroll = res_scroll;
            out_next.read_data  = res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            col_reg       <= '0;
            row_reg       <= '0;
            addr_reg      <= '0;
            base_reg      <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            wpend_reg     <= 1'b0;
            init_reg      <= 1'b1;
            scroll_reg    <= 1'b0;
            fill_word_reg <= RESET_WORD;
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            addr_reg      <= addr_next;
            base_reg      <= base_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            wpend_reg     <= wpend_next;
            init_reg      <= init_next;
            scroll_reg    <= scroll_next;
            fill_word_reg <= fill_word_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/text_console_writer_core.sv @@
`timescale 1ns / 1ps
// Top level of the text console writer: front end, command queue and execution engine.
// A put, newline without scroll or no-op gives its result beat from the result register;
// a read passes through the read data register as well; a clear and a scroll sweep the
// whole screen memory, one cell at a time through its single write port.
// The engine takes a new command only once the previous result beat has been taken.
// After reset the screen memory is swept to blanks with cmd_stall high.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  tcw_cmd_t   cmd_data,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output tcw_rsp_t   rsp_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    tcw_push_t  q_push;
    logic       q_full;
    logic       q_valid;
    logic       pop;
    logic       init_busy;
    tcw_entry_t head;

    assign cfg_ready = 1'b1;

    tcw_front #(
        .CELL_COUNT(COLUMNS * ROWS)
    ) u_front (
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_data (cmd_data),
        .q_full   (q_full),
        .init_busy(init_busy),
        .q_push   (q_push)
    );

    tcw_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .pop    (pop),
        .q_valid(q_valid),
        .head   (head)
    );

    tcw_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .head     (head),
        .pop      (pop),
        .init_busy(init_busy),
        .cfg_valid(cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data (rsp_data)
    );

endmodule

@@ rtl/tcw_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the text console writer and their binding to the top level.
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic     clk,
    input logic     rst_n,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input tcw_rsp_t rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("Result beat changed while stalled.");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp_data.cursor_col) < 32'(COLUMNS))
                   && (32'(rsp_data.cursor_row) < 32'(ROWS)))
        else $error("Cursor reported outside the screen.");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.did_scroll |->
            rsp_data.cursor_col == 7'd0 && rsp_data.cursor_row == 5'(ROWS - 1))
        else $error("Scroll did not leave the cursor at the start of the bottom row.");

    a_scroll_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.did_scroll |-> rsp_data.read_data == 16'd0)
        else $error("Scroll result carries read data.");

endmodule

bind text_console_writer_core tcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tcw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the text console writer with its own screen and cursor predictor.
module tb;
    import tcw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    tcw_cmd_t   cmd_data = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    tcw_rsp_t   rsp_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    text_console_writer_core #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_data(cmd_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data(rsp_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    logic [15:0] screen_mem [0:CELLS-1];
    int          cur_col;
    int          cur_row;
    logic [7:0]  text_attr;

    tcw_cmd_t pending_cmds[$];
    tcw_rsp_t expected_rsps[$];
    tcw_rsp_t want;
    int       n_issued = 0;
    int       n_checked = 0;
    int       errors = 0;
    bit       cmd_sent = 1'b0;
    bit       quiet = 1'b0;
    bit       hold_start = 1'b0;
    int       hold_left = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void reset_screen();
        int i;
        for (i = 0; i < CELLS; i++)
            screen_mem[i] = RESET_WORD;
        cur_col = 0;
        cur_row = 0;
        text_attr = ATTR_RESET;
    endfunction

    function automatic logic advance_row();
        int i;
        cur_col = 0;
        cur_row++;
        if (cur_row < ROWS)
            return 1'b0;
        for (i = 0; i < CELLS - COLUMNS; i++)
            screen_mem[i] = screen_mem[i + COLUMNS];
        for (i = CELLS - COLUMNS; i < CELLS; i++)
            screen_mem[i] = {text_attr, SPACE_CODE};
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    function automatic tcw_rsp_t console_step(tcw_cmd_t c);
        tcw_rsp_t r;
        int i;
        r = '0;
        case (c.mode)
            MODE_PUT:
            begin
                if (c.char_code == NEWLINE_CODE)
                begin
                    r.did_scroll = advance_row();
                end
                else
                begin
                    screen_mem[cur_row * COLUMNS + cur_col] = {text_attr, c.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                        r.did_scroll = advance_row();
                end
            end
            MODE_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    screen_mem[i] = {text_attr, SPACE_CODE};
                cur_col = 0;
                cur_row = 0;
            end
            MODE_READ:
            begin
                if (c.cell_index < CELLS)
                    r.read_data = screen_mem[c.cell_index];
            end
            default:
            begin
            end
        endcase
        r.cursor_col = cur_col[6:0];
        r.cursor_row = cur_row[4:0];
        return r;
    endfunction

    function automatic tcw_cmd_t random_cmd();
        tcw_cmd_t c;
        int pick;
        int spot;
        c.mode = MODE_PUT;
        c.char_code = 8'($urandom_range(0, 255));
        c.cell_index = 11'($urandom_range(0, 2047));
        pick = $urandom_range(0, 999);
        if (pick < 2)
        begin
            c.mode = MODE_CLEAR;
        end
        else if (pick < 17)
        begin
            c.mode = MODE_UNUSED;
        end
        else if (pick < 167)
        begin
            c.mode = MODE_READ;
            spot = $urandom_range(0, 9);
            if (spot < 2)
                c.cell_index = 11'($urandom_range(0, 2047));
            else if (spot < 6)
                c.cell_index = 11'($urandom_range(CELLS - 6 * COLUMNS, CELLS - 1));
            else
                c.cell_index = 11'($urandom_range(0, CELLS - 1));
        end
        else if (pick < 217)
        begin
            c.char_code = NEWLINE_CODE;
        end
        return c;
    endfunction

    task automatic queue_cmd(input logic [1:0] mode, input logic [7:0] code,
                             input logic [10:0] cell_idx);
        tcw_cmd_t c;
        c.mode = mode;
        c.char_code = code;
        c.cell_index = cell_idx;
        pending_cmds.push_back(c);
        n_issued++;
    endtask

    task automatic wait_drained();
        while (n_checked < n_issued)
            @(negedge clk);
    endtask

    task automatic write_attr(input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        text_attr = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] attr, input int count, input bit no_idle,
                             input bit hold);
        int k;
        write_attr(attr);
        quiet = no_idle;
        hold_start = hold;
        for (k = 0; k < count; k++)
        begin
            pending_cmds.push_back(random_cmd());
            n_issued++;
        end
        wait_drained();
        quiet = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            expected_rsps.push_back(console_step(cmd_data));
            cmd_sent = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!cmd_valid || cmd_sent)
        begin
            cmd_sent = 1'b0;
            if (pending_cmds.size() > 0 && (quiet || $urandom_range(0, 99) >= 25))
            begin
                cmd_data <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_left = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 25);
        end
    end

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none got %h", $time, rsp_data);
                errors++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                n_checked++;
                check_field("cursor_col", 16'(want.cursor_col), 16'(rsp_data.cursor_col));
                check_field("cursor_row", 16'(want.cursor_row), 16'(rsp_data.cursor_row));
                check_field("did_scroll", 16'(want.did_scroll), 16'(rsp_data.did_scroll));
                check_field("read_data", want.read_data, rsp_data.read_data);
            end
        end
    end

    initial
    begin
        reset_screen();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        queue_cmd(MODE_READ, 8'h00, 11'd0);
        queue_cmd(MODE_READ, 8'hFF, 11'd1999);
        queue_cmd(MODE_READ, 8'h00, 11'd2000);
        queue_cmd(MODE_READ, 8'h00, 11'd2047);
        queue_cmd(MODE_PUT, 8'h00, 11'd0);
        queue_cmd(MODE_PUT, 8'hFF, 11'd2047);
        queue_cmd(MODE_PUT, 8'h41, 11'd5);
        queue_cmd(MODE_PUT, 8'h80, 11'd0);
        queue_cmd(MODE_READ, 8'h00, 11'd0);
        queue_cmd(MODE_READ, 8'h00, 11'd1);
        queue_cmd(MODE_READ, 8'h00, 11'd2);
        queue_cmd(MODE_READ, 8'h00, 11'd3);
        queue_cmd(MODE_PUT, NEWLINE_CODE, 11'd0);
        queue_cmd(MODE_UNUSED, 8'hFF, 11'h7FF);
        queue_cmd(MODE_PUT, 8'h7F, 11'd0);
        queue_cmd(MODE_READ, 8'h00, 11'd80);
        queue_cmd(MODE_CLEAR, 8'hFF, 11'h7FF);
        queue_cmd(MODE_READ, 8'h00, 11'd0);
        queue_cmd(MODE_READ, 8'h00, 11'd80);
        queue_cmd(MODE_PUT, 8'h55, 11'd0);
        queue_cmd(MODE_READ, 8'h00, 11'd0);
        wait_drained();

        run_phase(8'h00, 200, 1'b0, 1'b0);
        run_phase(8'hFF, 200, 1'b0, 1'b1);
        run_phase(8'($urandom_range(0, 255)), 250, 1'b1, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 160, 1'b0, 1'b1);
        run_phase(8'($urandom_range(0, 255)), 160, 1'b0, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 160, 1'b0, 1'b0);

        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
